// ===== src/svop_pkg.sv =====
// ----------------------------------------------------------------------------
// svop_pkg
// Shared types, codes and helpers of the SNMP varbind OID/value parser.
// ----------------------------------------------------------------------------
package svop_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] OID_TAG      = 8'h06;
    localparam logic [7:0] ARC_SPLIT_1  = 8'd40;
    localparam logic [7:0] ARC_SPLIT_2  = 8'd80;

    typedef enum logic [3:0] {
        PH_SEARCH   = 4'd0,
        PH_OLEN     = 4'd1,
        PH_OLEN_EXT = 4'd2,
        PH_OID      = 4'd3,
        PH_VTAG     = 4'd4,
        PH_VLEN     = 4'd5,
        PH_VLEN_EXT = 4'd6,
        PH_VAL      = 4'd7,
        PH_DONE     = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ARC    = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_TAG    = 3'd1,
        ST_BAD_LEN   = 3'd2,
        ST_OID_TRUNC = 3'd3,
        ST_VAL_MISS  = 3'd4
    } status_t;

    // Results caused by one accepted byte, in delivery order:
    // first-byte arc pair, then one arc or value byte, then the status.
    typedef struct packed {
        logic        pair_valid;
        logic [1:0]  pair_a0;
        logic [7:0]  pair_a1;
        logic        item_valid;
        kind_t       item_kind;
        logic [31:0] item_data;
        logic        stat_valid;
        status_t     stat_code;
    } bundle_t;

    function automatic status_t pending_status(input phase_t ph);
        status_t st;
        st = ST_OK;
        unique case (ph)
            PH_SEARCH:   st = ST_NO_TAG;
            PH_OLEN:     st = ST_BAD_LEN;
            PH_OLEN_EXT: st = ST_BAD_LEN;
            PH_OID:      st = ST_OID_TRUNC;
            PH_VTAG:     st = ST_VAL_MISS;
            PH_VLEN:     st = ST_VAL_MISS;
            PH_VLEN_EXT: st = ST_VAL_MISS;
            PH_VAL:      st = ST_OK;
            default:     st = ST_OK;
        endcase
        return st;
    endfunction

endpackage

// ===== src/svop_front.sv =====
// ----------------------------------------------------------------------------
// svop_front
// Byte parser: tracks the BER framing and builds the result bundle of each byte.
// ----------------------------------------------------------------------------
module svop_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_packet,
    output logic                 bnd_push,
    output svop_pkg::bundle_t    bnd
);

    svop_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]       rem_reg, rem_next;
    logic [1:0]        lbl_reg, lbl_next;
    logic [31:0]       acc_reg, acc_next;
    logic              first_reg, first_next;
    svop_pkg::status_t outcome_reg, outcome_next;
    svop_pkg::status_t close_code;

    logic              go_flag;
    logic              is_val;
    logic [15:0]       rem_ext;
    logic [15:0]       rem_dec;
    logic [1:0]        lbl_dec;
    logic [31:0]       acc_shift;
    logic [1:0]        a0;
    logic [7:0]        a1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= svop_pkg::PH_SEARCH;
            rem_reg     <= '0;
            lbl_reg     <= '0;
            acc_reg     <= '0;
            first_reg   <= 1'b1;
            outcome_reg <= svop_pkg::ST_NO_TAG;
        end
        else
        begin
            phase_reg   <= phase_next;
            rem_reg     <= rem_next;
            lbl_reg     <= lbl_next;
            acc_reg     <= acc_next;
            first_reg   <= first_next;
            outcome_reg <= outcome_next;
        end
    end

    always_comb
    begin
        is_val    = (phase_reg == svop_pkg::PH_VLEN) || (phase_reg == svop_pkg::PH_VLEN_EXT);
        rem_ext   = {rem_reg[7:0], data_byte};
        rem_dec   = rem_reg - 16'd1;
        lbl_dec   = lbl_reg - 2'd1;
        acc_shift = {acc_reg[24:0], data_byte[6:0]};
        if (data_byte < svop_pkg::ARC_SPLIT_1)
        begin
            a0 = 2'd0;
        end
        else if (data_byte < svop_pkg::ARC_SPLIT_2)
        begin
            a0 = 2'd1;
        end
        else
        begin
            a0 = 2'd2;
        end
        a1 = data_byte - 8'(a0 * svop_pkg::ARC_SPLIT_1);
    end

    always_comb
    begin
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        lbl_next     = lbl_reg;
        acc_next     = acc_reg;
        first_next   = first_reg;
        outcome_next = outcome_reg;
        close_code   = outcome_reg;
        go_flag      = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                svop_pkg::PH_SEARCH:
                begin
                    if (data_byte == svop_pkg::OID_TAG)
                    begin
                        phase_next = svop_pkg::PH_OLEN;
                        go_flag    = 1'b1;
                    end
                end
                svop_pkg::PH_OLEN, svop_pkg::PH_VLEN:
                begin
                    if (!data_byte[7])
                    begin
                        rem_next = {8'h00, data_byte};
                        if (data_byte == 8'h00)
                        begin
                            if (is_val)
                            begin
                                phase_next   = svop_pkg::PH_DONE;
                                outcome_next = svop_pkg::ST_OK;
                            end
                            else
                            begin
                                phase_next = svop_pkg::PH_VTAG;
                                go_flag    = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = is_val ? svop_pkg::PH_VAL : svop_pkg::PH_OID;
                            go_flag    = 1'b1;
                        end
                    end
                    else if ((data_byte[6:0] == 7'd0) || (data_byte[6:0] > 7'd2))
                    begin
                        phase_next   = svop_pkg::PH_DONE;
                        outcome_next = svop_pkg::ST_BAD_LEN;
                    end
                    else
                    begin
                        lbl_next   = data_byte[1:0];
                        rem_next   = '0;
                        phase_next = is_val ? svop_pkg::PH_VLEN_EXT : svop_pkg::PH_OLEN_EXT;
                        go_flag    = 1'b1;
                    end
                end
                svop_pkg::PH_OLEN_EXT, svop_pkg::PH_VLEN_EXT:
                begin
                    rem_next = rem_ext;
                    lbl_next = lbl_dec;
                    if (lbl_dec == 2'd0)
                    begin
                        if (rem_ext == 16'd0)
                        begin
                            if (is_val)
                            begin
                                phase_next   = svop_pkg::PH_DONE;
                                outcome_next = svop_pkg::ST_OK;
                            end
                            else
                            begin
                                phase_next = svop_pkg::PH_VTAG;
                                go_flag    = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = is_val ? svop_pkg::PH_VAL : svop_pkg::PH_OID;
                            go_flag    = 1'b1;
                        end
                    end
                end
                svop_pkg::PH_OID:
                begin
                    if (first_reg)
                    begin
                        first_next = 1'b0;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                        if (!data_byte[7])
                        begin
                            acc_next = '0;
                        end
                    end
                    rem_next = rem_dec;
                    if (rem_dec == 16'd0)
                    begin
                        phase_next = svop_pkg::PH_VTAG;
                        go_flag    = 1'b1;
                    end
                end
                svop_pkg::PH_VTAG:
                begin
                    phase_next = svop_pkg::PH_VLEN;
                    go_flag    = 1'b1;
                end
                svop_pkg::PH_VAL:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == 16'd0)
                    begin
                        phase_next   = svop_pkg::PH_DONE;
                        outcome_next = svop_pkg::ST_OK;
                    end
                end
                default:
                begin
                end
            endcase
            if (go_flag)
            begin
                outcome_next = svop_pkg::pending_status(phase_next);
            end
            close_code = outcome_next;
            if (end_of_packet)
            begin
                phase_next   = svop_pkg::PH_SEARCH;
                rem_next     = '0;
                lbl_next     = '0;
                acc_next     = '0;
                first_next   = 1'b1;
                outcome_next = svop_pkg::ST_NO_TAG;
            end
        end
    end

    always_comb
    begin
        bnd = '0;
        if (accept)
        begin
            unique case (phase_reg)
                svop_pkg::PH_OID:
                begin
                    if (first_reg)
                    begin
                        bnd.pair_valid = 1'b1;
                        bnd.pair_a0    = a0;
                        bnd.pair_a1    = a1;
                    end
                    else if (!data_byte[7])
                    begin
                        bnd.item_valid = 1'b1;
                        bnd.item_kind  = svop_pkg::KIND_ARC;
                        bnd.item_data  = acc_shift;
                    end
                end
                svop_pkg::PH_VAL:
                begin
                    bnd.item_valid = 1'b1;
                    bnd.item_kind  = svop_pkg::KIND_VALUE;
                    bnd.item_data  = {24'h000000, data_byte};
                end
                default:
                begin
                end
            endcase
            if (end_of_packet)
            begin
                bnd.stat_valid = 1'b1;
                bnd.stat_code  = close_code;
            end
        end
    end

    assign bnd_push = accept && (bnd.pair_valid || bnd.item_valid || bnd.stat_valid);

endmodule

// ===== src/svop_fifo.sv =====
// ----------------------------------------------------------------------------
// svop_fifo
// Short bundle queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module svop_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  svop_pkg::bundle_t    wr_data,
    input  logic                 rd_en,
    output svop_pkg::bundle_t    rd_data,
    output logic                 full,
    output logic                 empty
);

    svop_pkg::bundle_t                  mem [svop_pkg::FIFO_DEPTH];
    logic [svop_pkg::FIFO_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [svop_pkg::FIFO_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [svop_pkg::FIFO_CW-1:0]       count_reg, count_next;
    logic                               do_wr;
    logic                               do_rd;

    assign full    = (count_reg == svop_pkg::FIFO_CW'(svop_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/svop_back.sv =====
// ----------------------------------------------------------------------------
// svop_back
// Result sequencer: unpacks each bundle into single result words.
// ----------------------------------------------------------------------------
module svop_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  svop_pkg::bundle_t    q_data,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  logic                 pop,
    output logic                 empty,
    output logic [1:0]           kind,
    output logic [31:0]          arc,
    output logic [7:0]           value_byte,
    output logic [2:0]           status,
    output logic                 last
);

    svop_pkg::bundle_t bnd_reg, bnd_next;
    logic [3:0]        flags_reg, flags_next;
    logic [3:0]        flags_after;

    // flags: pair first arc, pair second arc, arc or value, status
    always_comb
    begin
        flags_after = flags_reg;
        if (pop && (flags_reg != 4'd0))
        begin
            flags_after = flags_reg & (flags_reg - 4'd1);
        end
        q_pop      = (flags_after == 4'd0) && !q_empty;
        flags_next = flags_after;
        bnd_next   = bnd_reg;
        if (q_pop)
        begin
            flags_next = {q_data.stat_valid, q_data.item_valid,
                          q_data.pair_valid, q_data.pair_valid};
            bnd_next   = q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bnd_reg <= bnd_next;
    end

    always_comb
    begin
        kind       = svop_pkg::KIND_ARC;
        arc        = '0;
        value_byte = '0;
        status     = svop_pkg::ST_OK;
        last       = 1'b0;
        priority if (flags_reg[0])
        begin
            arc = {30'd0, bnd_reg.pair_a0};
        end
        else if (flags_reg[1])
        begin
            arc = {24'd0, bnd_reg.pair_a1};
        end
        else if (flags_reg[2])
        begin
            kind = bnd_reg.item_kind;
            if (bnd_reg.item_kind == svop_pkg::KIND_VALUE)
            begin
                value_byte = bnd_reg.item_data[7:0];
            end
            else
            begin
                arc = bnd_reg.item_data;
            end
        end
        else if (flags_reg[3])
        begin
            kind   = svop_pkg::KIND_STATUS;
            status = bnd_reg.stat_code;
            last   = 1'b1;
        end
    end

    assign empty = (flags_reg == 4'd0);

endmodule

// ===== src/snmp_varbind_oid_value_parser.sv =====
// ----------------------------------------------------------------------------
// snmp_varbind_oid_value_parser
// Streaming parser of the first OID/value pair of an SNMP response packet.
// ----------------------------------------------------------------------------
// Input side: write one packet byte per cycle with push while full is low;
// end_of_packet marks the final byte of the packet.
// Output side: while empty is low the oldest result word is on kind, arc,
// value_byte, status and last; pop takes it.
// Each byte gives zero to three words: OID arcs (kind 0), value bytes
// (kind 1) and, on the final byte, a status word (kind 2, last high).
// A failing status means the arcs already delivered must be discarded.
// Path: a byte's bundle is written into the queue at the edge that takes the
// byte, then loaded into the sequencer register that drives the result ports.
// Throughput: one byte per cycle in while full is low, one word per
// cycle out while pop is high. A four-entry bundle queue parts parser and
// sequencer: full rises only on a receiver stall or several words per byte.
// Reset: empties the queue and the sequencer and returns the parser to the
// search for the OID tag. A stalled receiver holds its word unchanged.
// ----------------------------------------------------------------------------
module snmp_varbind_oid_value_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_packet,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [31:0] arc,
    output logic [7:0]  value_byte,
    output logic [2:0]  status,
    output logic        last
);

    svop_pkg::bundle_t f_bnd;
    svop_pkg::bundle_t q_data;
    logic              f_push;
    logic              q_empty;
    logic              q_pop;
    logic              accept;

    assign accept = push && !full;

    svop_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_packet (end_of_packet),
        .bnd_push      (f_push),
        .bnd           (f_bnd)
    );

    svop_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data (f_bnd),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    svop_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_data),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .kind       (kind),
        .arc        (arc),
        .value_byte (value_byte),
        .status     (status),
        .last       (last)
    );

endmodule

// ===== src/svop_checker.sv =====
// ----------------------------------------------------------------------------
// svop_checker
// Port-level checks of the SNMP varbind OID/value parser.
// ----------------------------------------------------------------------------
module svop_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  kind,
    input logic [31:0] arc,
    input logic [7:0]  value_byte,
    input logic [2:0]  status,
    input logic        last
);

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (last || (kind == svop_pkg::KIND_STATUS))) |->
            (last && (kind == svop_pkg::KIND_STATUS)))
        else $error("last and status kind disagree");

    a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == svop_pkg::KIND_STATUS)) |->
            (arc == 32'd0 && value_byte == 8'd0 && status <= svop_pkg::ST_VAL_MISS))
        else $error("bad status word");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind != svop_pkg::KIND_STATUS)) |->
            ((status == svop_pkg::ST_OK) &&
             ((kind == svop_pkg::KIND_ARC && value_byte == 8'd0) ||
              (kind == svop_pkg::KIND_VALUE && arc == 32'd0))))
        else $error("bad data word");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(kind) && $stable(arc) && $stable(value_byte) &&
             $stable(status) && $stable(last)))
        else $error("word changed while stalled");

endmodule

bind snmp_varbind_oid_value_parser svop_checker u_svop_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .arc        (arc),
    .value_byte (value_byte),
    .status     (status),
    .last       (last)
);
